@@ hdl/baeu_pkg.sv @@
package baeu_pkg;

    localparam int CUM_WIDTH   = 24;
    localparam int LEAD_WIDTH  = 32;
    localparam int COUNT_WIDTH = 6;
    localparam int CARRY_WIDTH = 16;
    localparam int S_DATA_WIDTH = 48;
    localparam int M_DATA_WIDTH = 56;

    localparam logic [CUM_WIDTH-1:0] FREQ_TOTAL_RESET = 24'd65536;

    // Request kinds carried on the input tuser.
    localparam logic REQ_ENCODE    = 1'b0;
    localparam logic REQ_TERMINATE = 1'b1;

    // Sequencer of the top level.
    typedef enum logic [6:0] {
        ST_IDLE  = 7'b0000001,
        ST_DIVLO = 7'b0000010,
        ST_DIVHI = 7'b0000100,
        ST_CHECK = 7'b0001000,
        ST_SHIFT = 7'b0010000,
        ST_UNDER = 7'b0100000,
        ST_DONE  = 7'b1000000
    } enc_state_t;

    // Phase of the shared multiply and divide unit.
    typedef enum logic [2:0] {
        MD_IDLE = 3'b001,
        MD_MUL  = 3'b010,
        MD_DIV  = 3'b100
    } md_state_t;

endpackage

@@ hdl/binary_arithmetic_encoder_unit.sv @@
// Channel   | Direction | Handshake                      | Payload
// s_axis    | in        | s_axis_tvalid / s_axis_tready  | tuser: req_type; tdata: cum_low, cum_high
// m_axis    | out       | m_axis_tvalid / m_axis_tready  | tuser: error; tdata: lead and carry fields
// cfg       | in        | cfg_valid / cfg_ready          | cfg_data: frequency_total
//
// An encode request keeps s_axis_tready low while both bin edges are scaled in the shared multiply
// and divide unit, the bin is checked, the settled and straddling bits are normalised away and
// the result is loaded; a terminate request, or an encode with a zero total, goes straight to the
// load. Reset is synchronous and active low and returns the frequency total register to 65536.
// A finished result waits in the output register while the next request is worked on; the block
// stalls only when a second result is ready before the first is taken.
module binary_arithmetic_encoder_unit #(
    parameter int PRECISION     = 32,
    parameter int PENDING_WIDTH = 16
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [47:0] s_axis_tdata,   // [23:0] cum_low, [47:24] cum_high
    input  logic        s_axis_tuser,   // [0] req_type
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [55:0] m_axis_tdata,   // [31:0] lead_bits, [37:32] lead_count,
                                        // [38] carry_bit, [54:39] carry_count, [55] zero
    output logic        m_axis_tuser,   // [0] error
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [23:0] cfg_data        // frequency_total
);

    localparam int CW      = baeu_pkg::CUM_WIDTH;
    localparam int W_WIDTH = PRECISION + 1;
    localparam int PROD_W  = CW + W_WIDTH;
    localparam int PEXT_W  = (PENDING_WIDTH > baeu_pkg::CARRY_WIDTH) ?
                             PENDING_WIDTH : baeu_pkg::CARRY_WIDTH;
    localparam int NW      = baeu_pkg::COUNT_WIDTH;

    baeu_pkg::enc_state_t state_reg, state_next;

    // Coder state: the interval itself is also the working pair during a request.
    logic [PRECISION-1:0]     low_reg, low_next;
    logic [PRECISION-1:0]     high_reg, high_next;
    logic [PENDING_WIDTH-1:0] pend_reg, pend_next;
    logic [CW-1:0]            ftot_reg, ftot_next;

    // Per-request working registers.
    logic [W_WIDTH-1:0]       w_reg, w_next;
    logic [CW-1:0]            ch_reg, ch_next;
    logic [PROD_W-1:0]        ql_reg, ql_next;
    logic [PROD_W-1:0]        qh_reg, qh_next;
    logic [31:0]              bits_reg, bits_next;
    logic [NW-1:0]            cnt_reg, cnt_next;
    logic [NW-1:0]            guard_reg, guard_next;
    logic                     cbit_reg, cbit_next;
    logic [15:0]              ccnt_reg, ccnt_next;
    logic                     err_reg, err_next;

    // Output register.
    logic                     mval_reg, mval_next;
    logic [55:0]              mdata_reg, mdata_next;
    logic                     muser_reg, muser_next;

    // Shared unit hookup.
    logic                     md_start;
    logic [CW-1:0]            md_a;
    logic                     md_done;
    logic [PROD_W-1:0]        md_quot;

    logic                     s_accept;
    logic [PEXT_W-1:0]        pend_ext;
    logic                     emit_bit;
    logic [2:0]               lo_quarter;
    logic [2:0]               hi_quarter;

    baeu_muldiv #(
        .W_WIDTH(W_WIDTH)
    ) u_muldiv (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (md_start),
        .mult_a  (md_a),
        .mult_w  (w_next),
        .divisor (ftot_reg),
        .done    (md_done),
        .quot    (md_quot)
    );

    assign s_axis_tready = (state_reg == baeu_pkg::ST_IDLE);
    assign s_accept      = s_axis_tvalid & s_axis_tready;
    assign cfg_ready     = 1'b1;
    assign pend_ext      = PEXT_W'(pend_reg);
    assign emit_bit      = low_reg[PRECISION-1];
    assign lo_quarter    = {1'b0, low_reg[PRECISION-1:PRECISION-2]} + 3'd1;
    assign hi_quarter    = {1'b0, high_reg[PRECISION-1:PRECISION-2]};

    always_comb begin
        state_next = state_reg;
        low_next   = low_reg;
        high_next  = high_reg;
        pend_next  = pend_reg;
        ftot_next  = ftot_reg;
        w_next     = w_reg;
        ch_next    = ch_reg;
        ql_next    = ql_reg;
        qh_next    = qh_reg;
        bits_next  = bits_reg;
        cnt_next   = cnt_reg;
        guard_next = guard_reg;
        cbit_next  = cbit_reg;
        ccnt_next  = ccnt_reg;
        err_next   = err_reg;
        mval_next  = mval_reg;
        mdata_next = mdata_reg;
        muser_next = muser_reg;
        md_start   = 1'b0;
        md_a       = s_axis_tdata[CW-1:0];

        if (m_axis_tready) begin
            mval_next = 1'b0;
        end
        if (cfg_valid) begin
            ftot_next = cfg_data;
        end

        case (state_reg)
            baeu_pkg::ST_IDLE: begin
                if (s_accept) begin
                    bits_next  = '0;
                    cnt_next   = '0;
                    cbit_next  = 1'b0;
                    ccnt_next  = '0;
                    err_next   = 1'b0;
                    state_next = baeu_pkg::ST_DONE;
                    if (s_axis_tuser == baeu_pkg::REQ_TERMINATE) begin
                        // Top bit of low, then the pending ones; the coder starts afresh.
                        bits_next = {emit_bit, 31'd0};
                        cnt_next  = NW'(1);
                        cbit_next = (pend_reg != '0);
                        ccnt_next = pend_ext[15:0];
                        low_next  = '0;
                        high_next = '1;
                        pend_next = '0;
                    end else if (ftot_reg == '0) begin
                        err_next = 1'b1;
                    end else begin
                        w_next     = W_WIDTH'(high_reg - low_reg) + W_WIDTH'(1);
                        ch_next    = s_axis_tdata[2*CW-1:CW];
                        md_start   = 1'b1;
                        state_next = baeu_pkg::ST_DIVLO;
                    end
                end
            end
            baeu_pkg::ST_DIVLO: begin
                if (md_done) begin
                    ql_next    = md_quot;
                    md_a       = ch_reg;
                    md_start   = 1'b1;
                    state_next = baeu_pkg::ST_DIVHI;
                end
            end
            baeu_pkg::ST_DIVHI: begin
                if (md_done) begin
                    qh_next    = md_quot;
                    state_next = baeu_pkg::ST_CHECK;
                end
            end
            baeu_pkg::ST_CHECK: begin
                // A collapsed, inverted or out-of-range bin leaves the coder untouched.
                if (qh_reg <= ql_reg || qh_reg > PROD_W'(w_reg)) begin
                    err_next   = 1'b1;
                    state_next = baeu_pkg::ST_DONE;
                end else begin
                    low_next   = low_reg + ql_reg[PRECISION-1:0];
                    high_next  = low_reg + qh_reg[PRECISION-1:0] - PRECISION'(1);
                    state_next = baeu_pkg::ST_SHIFT;
                end
            end
            baeu_pkg::ST_SHIFT: begin
                // One settled bit a cycle; pending bits follow the first of them.
                if (cnt_reg < NW'(PRECISION) && emit_bit == high_reg[PRECISION-1]) begin
                    bits_next = bits_reg | (32'(emit_bit) << (5'd31 - cnt_reg[4:0]));
                    if (cnt_reg == '0 && pend_reg != '0) begin
                        cbit_next = ~emit_bit;
                        ccnt_next = pend_ext[15:0];
                        pend_next = '0;
                    end
                    cnt_next  = cnt_reg + NW'(1);
                    low_next  = {low_reg[PRECISION-2:0], 1'b0};
                    high_next = {high_reg[PRECISION-2:0], 1'b1};
                end else begin
                    guard_next = '0;
                    state_next = baeu_pkg::ST_UNDER;
                end
            end
            baeu_pkg::ST_UNDER: begin
                // Drop the second bit while the interval straddles the midpoint.
                if (guard_reg < NW'(PRECISION) && lo_quarter == hi_quarter) begin
                    if (&pend_reg) begin
                        err_next = 1'b1;
                    end else begin
                        pend_next = pend_reg + PENDING_WIDTH'(1);
                    end
                    low_next   = {low_reg[PRECISION-1], low_reg[PRECISION-3:0], 1'b0};
                    high_next  = {high_reg[PRECISION-1], high_reg[PRECISION-3:0], 1'b1};
                    guard_next = guard_reg + NW'(1);
                end else begin
                    state_next = baeu_pkg::ST_DONE;
                end
            end
            baeu_pkg::ST_DONE: begin
                if (!mval_reg || m_axis_tready) begin
                    mval_next  = 1'b1;
                    mdata_next = {1'b0, ccnt_reg, cbit_reg, cnt_reg, bits_reg};
                    muser_next = err_reg;
                    state_next = baeu_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = baeu_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= baeu_pkg::ST_IDLE;
            low_reg   <= '0;
            high_reg  <= '1;
            pend_reg  <= '0;
            ftot_reg  <= baeu_pkg::FREQ_TOTAL_RESET;
            mval_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;
            low_reg   <= low_next;
            high_reg  <= high_next;
            pend_reg  <= pend_next;
            ftot_reg  <= ftot_next;
            mval_reg  <= mval_next;
        end
        w_reg     <= w_next;
        ch_reg    <= ch_next;
        ql_reg    <= ql_next;
        qh_reg    <= qh_next;
        bits_reg  <= bits_next;
        cnt_reg   <= cnt_next;
        guard_reg <= guard_next;
        cbit_reg  <= cbit_next;
        ccnt_reg  <= ccnt_next;
        err_reg   <= err_next;
        mdata_reg <= mdata_next;
        muser_reg <= muser_next;
    end

    assign m_axis_tvalid = mval_reg;
    assign m_axis_tdata  = mdata_reg;
    assign m_axis_tuser  = muser_reg;

endmodule

@@ hdl/baeu_muldiv.sv @@
// Shared shift-add multiplier followed by a restoring divider, one bit a cycle.
// quot = floor(mult_a * mult_w / divisor); the divisor must be nonzero.
module baeu_muldiv #(
    parameter int W_WIDTH = 33
) (
    input  logic                                       aclk,
    input  logic                                       aresetn,
    input  logic                                       start,
    input  logic [baeu_pkg::CUM_WIDTH-1:0]             mult_a,
    input  logic [W_WIDTH-1:0]                         mult_w,
    input  logic [baeu_pkg::CUM_WIDTH-1:0]             divisor,
    output logic                                       done,
    output logic [baeu_pkg::CUM_WIDTH+W_WIDTH-1:0]     quot
);

    localparam int PROD_W = baeu_pkg::CUM_WIDTH + W_WIDTH;
    localparam int CNT_W  = $clog2(PROD_W + 1);
    localparam int CW     = baeu_pkg::CUM_WIDTH;

    baeu_pkg::md_state_t state_reg, state_next;
    logic [PROD_W-1:0] acc_reg, acc_next;
    logic [CW-1:0]     a_reg, a_next;
    logic [W_WIDTH-1:0] w_reg, w_next;
    logic [CW-1:0]     d_reg, d_next;
    logic [CW-1:0]     rem_reg, rem_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic              done_reg, done_next;
    logic [CW:0]       rem_sh;
    logic [CW:0]       rem_sub;
    logic              qbit;

    assign rem_sh  = {rem_reg, acc_reg[PROD_W-1]};
    assign rem_sub = rem_sh - {1'b0, d_reg};
    assign qbit    = ~rem_sub[CW];

    always_comb begin
        state_next = state_reg;
        acc_next   = acc_reg;
        a_next     = a_reg;
        w_next     = w_reg;
        d_next     = d_reg;
        rem_next   = rem_reg;
        cnt_next   = cnt_reg;
        done_next  = 1'b0;
        case (state_reg)
            baeu_pkg::MD_IDLE: begin
                if (start) begin
                    acc_next   = '0;
                    a_next     = mult_a;
                    w_next     = mult_w;
                    d_next     = divisor;
                    rem_next   = '0;
                    cnt_next   = CNT_W'(CW);
                    state_next = baeu_pkg::MD_MUL;
                end
            end
            baeu_pkg::MD_MUL: begin
                acc_next = {acc_reg[PROD_W-2:0], 1'b0}
                           + (a_reg[CW-1] ? PROD_W'(w_reg) : '0);
                a_next   = {a_reg[CW-2:0], 1'b0};
                cnt_next = cnt_reg - 1'b1;
                if (cnt_reg == CNT_W'(1)) begin
                    cnt_next   = CNT_W'(PROD_W);
                    state_next = baeu_pkg::MD_DIV;
                end
            end
            baeu_pkg::MD_DIV: begin
                rem_next = qbit ? rem_sub[CW-1:0] : rem_sh[CW-1:0];
                acc_next = {acc_reg[PROD_W-2:0], qbit};
                cnt_next = cnt_reg - 1'b1;
                if (cnt_reg == CNT_W'(1)) begin
                    done_next  = 1'b1;
                    state_next = baeu_pkg::MD_IDLE;
                end
            end
            default: begin
                state_next = baeu_pkg::MD_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= baeu_pkg::MD_IDLE;
            done_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;
            done_reg  <= done_next;
        end
        acc_reg <= acc_next;
        a_reg   <= a_next;
        w_reg   <= w_next;
        d_reg   <= d_next;
        rem_reg <= rem_next;
        cnt_reg <= cnt_next;
    end

    assign done = done_reg;
    assign quot = acc_reg;

endmodule
